/* hdl/wbss_pkg.sv */
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner package
// Shared register indexes, pattern widths and the configuration bundle.
// ----------------------------------------------------------------------------
package wbss_pkg;

    // Widths fixed by the register map.
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CARE_W     = 16;
    // The match address field never carries more than this many bits.
    localparam int OUT_ADDR_LIMIT = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_CARE_MASK    = 2'd2,
        CFG_PATTERN_LEN  = 2'd3
    } cfg_index_t;

    // Configuration seen by the match logic.
    typedef struct packed {
        logic [PAT_BYTES*8-1:0] pattern;
        logic [CARE_W-1:0]      care;
        logic [LEN_W-1:0]       length;
    } wbss_cfg_t;

endpackage

/* hdl/wbss_match.sv */
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner - window compare
// Compares the sliding window against the pattern under the care mask.
// ----------------------------------------------------------------------------
module wbss_match #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wbss_pkg::wbss_cfg_t                      cfg,
    input  logic [MAX_PATTERN_BYTES*8-1:0]           window,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]   fill,
    output logic                                     hit,
    output logic [wbss_pkg::LEN_W-1:0]               len_minus_one
);
    import wbss_pkg::*;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] pos [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] miss;

    // A zero length acts as one; anything above the window depth is clamped.
    always_comb
    begin
        if (cfg.length == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (cfg.length > LEN_W'(MAX_PATTERN_BYTES))
        begin
            eff_len = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            eff_len = cfg.length;
        end
    end

    assign len_minus_one = eff_len - LEN_W'(1);

    // Window entry j lines up with pattern byte (length - 1 - j).
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            pos[j]  = len_minus_one - LEN_W'(j);
            miss[j] = (LEN_W'(j) < eff_len) && cfg.care[pos[j][PAT_IDX_W-1:0]] &&
                      (window[j*8 +: 8] != cfg.pattern[pos[j][PAT_IDX_W-1:0]*8 +: 8]);
        end
    end

    assign hit = (LEN_W'(fill) >= eff_len) && (miss == '0);

endmodule

/* hdl/wildcard_byte_signature_scanner.sv */
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner
// Slides a window over a byte stream and reports the start address of every
// window that matches a masked pattern of up to sixteen bytes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload (low bit first)              Transfer when
//  s_*       in   tdata: data_byte, byte_address       s_tvalid & s_tready
//                 tuser: region_start
//  m_*       out  tdata: match_address                 m_tvalid & m_tready
//  cfg_*     in   cfg_index, cfg_data                  cfg_valid & cfg_ready
//
// One byte is taken per cycle while the compare stage can move. A byte enters
// the window on transfer, is compared from the window register and, when that
// stage advances, its match is loaded into the output register. Reset empties
// the window and loads the register defaults. A stalled output holds back the
// compare stage only while it holds a match; the input side stops only then.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int ADDRESS_BITS      = 48
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // data_byte [7:0], byte_address above it, zero padding to whole bytes
    input  logic [((8+ADDRESS_BITS+7)/8)*8-1:0]    s_tdata,
    // region_start
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // match_address, zero padding to whole bytes
    output logic [((ADDRESS_BITS+7)/8)*8-1:0]      m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  wbss_pkg::cfg_index_t                   cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import wbss_pkg::*;

    localparam int FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int M_W       = ((ADDRESS_BITS + 7) / 8) * 8;
    localparam int KEEP_BITS = (ADDRESS_BITS < OUT_ADDR_LIMIT) ? ADDRESS_BITS : OUT_ADDR_LIMIT;
    localparam logic [ADDRESS_BITS-1:0] OUT_MASK =
        {ADDRESS_BITS{1'b1}} >> (ADDRESS_BITS - KEEP_BITS);

    // Configuration registers.
    wbss_cfg_t cfg_reg;

    // Window and compare stage.
    logic [7:0]              window_reg  [MAX_PATTERN_BYTES];
    logic [7:0]              window_next [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES*8-1:0] window_flat;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic                    s1_valid_reg;
    logic [ADDRESS_BITS-1:0] s1_addr_reg;

    // Output register.
    logic                    out_valid_reg;
    logic [ADDRESS_BITS-1:0] out_addr_reg;

    logic                    in_xfer;
    logic                    s1_advance;
    logic                    hit;
    logic [LEN_W-1:0]        len_minus_one;
    logic [7:0]              in_byte;
    logic [ADDRESS_BITS-1:0] in_addr;
    logic                    in_start;

    assign in_byte  = s_tdata[7:0];
    assign in_addr  = s_tdata[8 +: ADDRESS_BITS];
    assign in_start = s_tuser[0];

    // A compare result that is not a match never waits for the output.
    assign s1_advance = s1_valid_reg && (!hit || !out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        window_next[0] = in_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            window_next[k] = in_start ? 8'h00 : window_reg[k-1];
        end
        if (in_start)
        begin
            fill_next = FILL_W'(1);
        end
        else if (fill_reg < FILL_W'(MAX_PATTERN_BYTES))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            window_flat[k*8 +: 8] = window_reg[k];
        end
    end

    wbss_match #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_match (
        .cfg          (cfg_reg),
        .window       (window_flat),
        .fill         (fill_reg),
        .hit          (hit),
        .len_minus_one(len_minus_one)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern <= '0;
            cfg_reg.care    <= '0;
            cfg_reg.length  <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  cfg_reg.pattern[CFG_DATA_W-1:0] <= cfg_data;
                CFG_PATTERN_HIGH: cfg_reg.pattern[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
                CFG_CARE_MASK:    cfg_reg.care   <= cfg_data[CARE_W-1:0];
                CFG_PATTERN_LEN:  cfg_reg.length <= cfg_data[LEN_W-1:0];
                default:          cfg_reg.length <= cfg_reg.length;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                fill_reg <= fill_next;
            end
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance && hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the fill count gates stale entries.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            window_reg  <= window_next;
            s1_addr_reg <= in_addr;
        end
        if (s1_advance && hit)
        begin
            out_addr_reg <= (s1_addr_reg - ADDRESS_BITS'(len_minus_one)) & OUT_MASK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_W'(out_addr_reg);

    // The compare stage holds its item while the output is blocked.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("compare stage lost its item while stalled");

    // The fill count saturates at the window depth.
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_PATTERN_BYTES))
        else $error("window fill count beyond depth");

    // A region start leaves exactly one byte in the window.
    a_region_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_start |=> fill_reg == FILL_W'(1))
        else $error("window not restarted at region start");

endmodule
